// File: hw/rtl/srpb_pkg.sv
// ----------------------------------------------------------------------------
// srpb_pkg: shared definitions for the sprite row plane blitter
// Plane widths, action and colour codes, the row word and the sequencer states.
// ----------------------------------------------------------------------------
package srpb_pkg;

  localparam int unsigned SCREEN_ROWS_DEF = 64;
  localparam int unsigned SPRITE_SIZE     = 8;
  localparam int unsigned PLANE_W         = 64;
  // bit position of the sprite line: 63 - column - sprite size
  localparam int          PLACE_BASE      = 63 - 8;

  typedef enum logic [1:0] {
    ACT_DRAW  = 2'd0,
    ACT_READ  = 2'd1,
    ACT_CLEAR = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  localparam logic [3:0] COLOUR_OFF   = 4'd0;
  localparam logic [3:0] COLOUR_WHITE = 4'd7;

  localparam logic [1:0] KIND_FRIEND = 2'd1;
  localparam logic [1:0] KIND_ENEMY  = 2'd2;
  localparam logic [1:0] KIND_LIFE   = 2'd3;

  // one frame row: six planes side by side
  typedef struct packed {
    logic [PLANE_W-1:0] blue;
    logic [PLANE_W-1:0] red;
    logic [PLANE_W-1:0] green;
    logic [PLANE_W-1:0] friend_p;
    logic [PLANE_W-1:0] enemy;
    logic [PLANE_W-1:0] life;
  } row_t;

  // draw request as seen by the row update logic
  typedef struct packed {
    logic signed [7:0] left_column;
    logic [7:0]        sprite_bits;
    logic [3:0]        colour;
    logic [1:0]        object_kind;
  } draw_req_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_t;

endpackage

// File: hw/rtl/srpb_row_update.sv
// ----------------------------------------------------------------------------
// srpb_row_update: modify step of the row read-modify-write
// Places the sprite line in a 64-bit mask and merges it into the row planes.
// ----------------------------------------------------------------------------
module srpb_row_update (
  input  srpb_pkg::row_t      row_in,
  input  srpb_pkg::draw_req_t req,
  output srpb_pkg::row_t      row_out
);
  import srpb_pkg::*;

  logic signed [9:0]  shift_s;
  logic [9:0]         shift_n;
  logic [PLANE_W-1:0] bits_w;
  logic [PLANE_W-1:0] mask;
  logic               paint;

  // shift amount, left for non-negative, right otherwise
  assign shift_s = 10'(PLACE_BASE) - {{2{req.left_column[7]}}, req.left_column};
  assign shift_n = 10'(-shift_s);
  assign bits_w  = {{(PLANE_W-8){1'b0}}, req.sprite_bits};

  always_comb begin
    if (!shift_s[9]) begin
      mask = (shift_s >= 10'sd64) ? '0 : (bits_w << shift_s[5:0]);
    end else begin
      mask = (shift_n >= 10'd64) ? '0 : (bits_w >> shift_n[5:0]);
    end
  end

  // clear colour under mask; non-zero colour paints and marks the object plane
  assign paint = (req.colour != COLOUR_OFF);

  always_comb begin
    row_out       = row_in;
    row_out.blue  = row_in.blue  & ~mask;
    row_out.red   = row_in.red   & ~mask;
    row_out.green = row_in.green & ~mask;
    if (paint && req.colour <= COLOUR_WHITE) begin
      if (req.colour[0]) row_out.blue  = row_out.blue  | mask;
      if (req.colour[1]) row_out.green = row_out.green | mask;
      if (req.colour[2]) row_out.red   = row_out.red   | mask;
    end
    if (paint) begin
      case (req.object_kind)
        KIND_FRIEND: row_out.friend_p = row_in.friend_p | mask;
        KIND_ENEMY:  row_out.enemy    = row_in.enemy    | mask;
        KIND_LIFE:   row_out.life     = row_in.life     | mask;
        default:     row_out.life     = row_in.life;
      endcase
    end
  end

endmodule

// File: hw/rtl/sprite_row_plane_blitter.sv
// ----------------------------------------------------------------------------
// sprite_row_plane_blitter: bitplane sprite blitter over a frame row store
// Draw, read and clear requests on rows of six 64-bit planes.
// ----------------------------------------------------------------------------
// Requests do not overlap: busy holds off a new one while the single row memory
//   port is read at accept and written back in the following cycle.
// A read result is registered into the result register and out_valid during execute.
// The receiver cannot stall; out_valid is a one-cycle strobe.
// Reset: per-row valid bits clear at once, an unwritten row reads as zero;
//   no clearing pass, the block is ready right after reset.
module sprite_row_plane_blitter #(
  parameter int unsigned SCREEN_ROWS = srpb_pkg::SCREEN_ROWS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   in_action,
  input  logic signed [7:0]            in_top_row,
  input  logic [2:0]                   in_line_index,
  input  logic signed [7:0]            in_left_column,
  input  logic [7:0]                   in_sprite_bits,
  input  logic [3:0]                   in_colour,
  input  logic [1:0]                   in_object_kind,
  output logic                         out_valid,
  output logic [srpb_pkg::PLANE_W-1:0] out_blue_plane,
  output logic [srpb_pkg::PLANE_W-1:0] out_red_plane,
  output logic [srpb_pkg::PLANE_W-1:0] out_green_plane,
  output logic [srpb_pkg::PLANE_W-1:0] out_friend_plane,
  output logic [srpb_pkg::PLANE_W-1:0] out_enemy_plane,
  output logic [srpb_pkg::PLANE_W-1:0] out_life_plane
);
  import srpb_pkg::*;

  localparam int unsigned AW = (SCREEN_ROWS > 1) ? $clog2(SCREEN_ROWS) : 1;

  // row store and per-row valid bits
  row_t                   mem [SCREEN_ROWS];
  logic [SCREEN_ROWS-1:0] valid_r, valid_nxt;

  state_t    state_r, state_nxt;
  logic      accept;
  logic signed [9:0] row_sel;
  logic      on_screen;
  logic [AW-1:0] addr;

  logic [AW-1:0] addr_r;
  logic          on_screen_r;
  action_t       action_r;
  draw_req_t     req_r;
  logic          row_valid_r;
  row_t          rd_data_r;
  row_t          cur_row;
  row_t          new_row;
  logic          wr_en;

  logic          out_valid_r, out_valid_nxt;
  row_t          out_row_r;

  assign accept = start && (state_r == ST_IDLE);
  assign busy   = (state_r == ST_EXEC);

  // target row: top + line for draw, top alone for read and clear
  always_comb begin
    if (action_t'(in_action) == ACT_DRAW) begin
      row_sel = {{2{in_top_row[7]}}, in_top_row} + {7'd0, in_line_index};
    end else begin
      row_sel = {{2{in_top_row[7]}}, in_top_row};
    end
  end
  assign on_screen = !row_sel[9] && (row_sel < 10'(SCREEN_ROWS));
  assign addr      = row_sel[AW-1:0];

  // request capture
  always_ff @(posedge clk) begin
    if (accept) begin
      addr_r      <= addr;
      on_screen_r <= on_screen;
      action_r    <= action_t'(in_action);
      req_r       <= '{left_column: in_left_column, sprite_bits: in_sprite_bits,
                       colour: in_colour, object_kind: in_object_kind};
      row_valid_r <= valid_r[addr];
    end
  end

  // row memory: read at accept, write back during execute
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_data_r <= mem[addr];
    end
    if (wr_en) begin
      mem[addr_r] <= new_row;
    end
  end

  assign cur_row = row_valid_r ? rd_data_r : '0;

  srpb_row_update u_update (
    .row_in  (cur_row),
    .req     (req_r),
    .row_out (new_row)
  );

  assign wr_en = (state_r == ST_EXEC) && on_screen_r && (action_r == ACT_DRAW);

  // valid bits: set by a draw, cleared by a clear
  always_comb begin
    valid_nxt = valid_r;
    if (state_r == ST_EXEC && on_screen_r) begin
      if (action_r == ACT_DRAW)  valid_nxt[addr_r] = 1'b1;
      if (action_r == ACT_CLEAR) valid_nxt[addr_r] = 1'b0;
    end
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (accept) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        state_nxt     = ST_IDLE;
        out_valid_nxt = (action_r == ACT_READ);
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result register, zero for an off-screen read
  always_ff @(posedge clk) begin
    if (state_r == ST_EXEC && action_r == ACT_READ) begin
      out_row_r <= on_screen_r ? cur_row : '0;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_blue_plane   = out_row_r.blue;
  assign out_red_plane    = out_row_r.red;
  assign out_green_plane  = out_row_r.green;
  assign out_friend_plane = out_row_r.friend_p;
  assign out_enemy_plane  = out_row_r.enemy;
  assign out_life_plane   = out_row_r.life;

endmodule

// File: verif/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: sprite row plane blitter
// Drives draw, read and clear requests with random gaps and predicts the frame
// store row by row. Every read result is checked plane by plane against the
// oldest outstanding prediction.
// ----------------------------------------------------------------------------
module testbench;
  import srpb_pkg::*;

  localparam int unsigned ROWS       = SCREEN_ROWS_DEF;
  localparam int          TOTAL_REQS = 1175;
  localparam int          IDLE_LIMIT = 1000;
  localparam logic [3:0]  COLOUR_FILL = 4'd8;

  // --------------------------------------------------------------------------
  // frame store model and queue of predicted read results
  // --------------------------------------------------------------------------
  class frame_predictor;
    row_t frame_rows [ROWS];
    row_t pending_reads [$];
    int   errors;

    function new();
      foreach (frame_rows[k]) frame_rows[k] = '0;
      errors = 0;
    endfunction

    // update the model for one accepted request
    function void note_request(action_t act, logic signed [7:0] top, logic [2:0] line,
                               logic signed [7:0] col, logic [7:0] bits,
                               logic [3:0] colour, logic [1:0] kind);
      int          row;
      int          shift;
      logic [63:0] mask;
      row_t        cur;
      case (act)
        ACT_DRAW: begin
          row = int'(top) + int'(line);
          if (row >= 0 && row < ROWS) begin
            // placement: positive shift moves left, negative right
            shift = PLACE_BASE - int'(col);
            if (shift >= 64 || shift <= -64) mask = '0;
            else if (shift >= 0) mask = {56'd0, bits} << shift;
            else mask = {56'd0, bits} >> (-shift);
            cur = frame_rows[row];
            cur.blue  &= ~mask;
            cur.red   &= ~mask;
            cur.green &= ~mask;
            if (colour != COLOUR_OFF) begin
              // colour bit 0 blue, bit 1 green, bit 2 red; fill codes set none
              if (colour <= COLOUR_WHITE) begin
                if (colour[0]) cur.blue  |= mask;
                if (colour[1]) cur.green |= mask;
                if (colour[2]) cur.red   |= mask;
              end
              case (kind)
                KIND_FRIEND: cur.friend_p |= mask;
                KIND_ENEMY:  cur.enemy    |= mask;
                KIND_LIFE:   cur.life     |= mask;
                default: ;
              endcase
            end
            frame_rows[row] = cur;
          end
        end
        ACT_READ: begin
          if (top >= 0 && int'(top) < ROWS) pending_reads.push_back(frame_rows[top]);
          else pending_reads.push_back('0);
        end
        ACT_CLEAR: begin
          if (top >= 0 && int'(top) < ROWS) frame_rows[top] = '0;
        end
        default: ;
      endcase
    endfunction

    function void compare_plane(string name, logic [63:0] exp, logic [63:0] got);
      if (got !== exp) begin
        $display("%0t: %s plane mismatch, expected %h, actual %h", $time, name, exp, got);
        errors++;
      end
    endfunction

    // check one read result against the oldest prediction
    function void check_read(row_t got);
      row_t exp;
      if (pending_reads.size() == 0) begin
        $display("%0t: read result with none expected, expected none, actual %h",
                 $time, got);
        errors++;
      end else begin
        exp = pending_reads.pop_front();
        compare_plane("blue",   exp.blue,     got.blue);
        compare_plane("red",    exp.red,      got.red);
        compare_plane("green",  exp.green,    got.green);
        compare_plane("friend", exp.friend_p, got.friend_p);
        compare_plane("enemy",  exp.enemy,    got.enemy);
        compare_plane("life",   exp.life,     got.life);
      end
    endfunction
  endclass

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  logic [1:0]        in_action;
  logic signed [7:0] in_top_row;
  logic [2:0]        in_line_index;
  logic signed [7:0] in_left_column;
  logic [7:0]        in_sprite_bits;
  logic [3:0]        in_colour;
  logic [1:0]        in_object_kind;
  logic              out_valid;
  logic [63:0]       out_blue_plane;
  logic [63:0]       out_red_plane;
  logic [63:0]       out_green_plane;
  logic [63:0]       out_friend_plane;
  logic [63:0]       out_enemy_plane;
  logic [63:0]       out_life_plane;

  frame_predictor sb;
  bit             no_idle;
  int             sent;
  int             idle_cycles;

  sprite_row_plane_blitter DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_action        (in_action),
    .in_top_row       (in_top_row),
    .in_line_index    (in_line_index),
    .in_left_column   (in_left_column),
    .in_sprite_bits   (in_sprite_bits),
    .in_colour        (in_colour),
    .in_object_kind   (in_object_kind),
    .out_valid        (out_valid),
    .out_blue_plane   (out_blue_plane),
    .out_red_plane    (out_red_plane),
    .out_green_plane  (out_green_plane),
    .out_friend_plane (out_friend_plane),
    .out_enemy_plane  (out_enemy_plane),
    .out_life_plane   (out_life_plane)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // monitor: results first, then the request accepted at this edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid)
        sb.check_read(row_t'({out_blue_plane, out_red_plane, out_green_plane,
                              out_friend_plane, out_enemy_plane, out_life_plane}));
      if (start && !busy)
        sb.note_request(action_t'(in_action), in_top_row, in_line_index, in_left_column,
                        in_sprite_bits, in_colour, in_object_kind);
    end
  end

  // watchdog on cycles with no handshake and no result
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // one request: random gap, drive at the falling edge, hold until accepted
  task automatic request(input action_t act, input logic signed [7:0] top,
                         input logic [2:0] line, input logic signed [7:0] col,
                         input logic [7:0] bits, input logic [3:0] colour,
                         input logic [1:0] kind);
    int gap;
    if ($urandom_range(0, 39) == 0) no_idle = !no_idle;
    gap = no_idle ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_action      <= act;
    in_top_row     <= top;
    in_line_index  <= line;
    in_left_column <= col;
    in_sprite_bits <= bits;
    in_colour      <= colour;
    in_object_kind <= kind;
    start          <= 1'b1;
    do @(posedge clk); while (busy);
    @(negedge clk);
    sent++;
  endtask

  task automatic read_row(input int row);
    request(ACT_READ, row[7:0], 3'($urandom), 8'($urandom), 8'($urandom),
            4'($urandom), 2'($urandom));
  endtask

  initial begin
    int          t;
    int          c;
    int          r;
    int          group;
    bit          broken;
    logic [3:0]  clr;
    logic [1:0]  kd;

    sb             = new();
    no_idle        = 1'b0;
    sent           = 0;
    idle_cycles    = 0;
    rst_n          = 1'b0;
    start          = 1'b0;
    in_action      = '0;
    in_top_row     = '0;
    in_line_index  = '0;
    in_left_column = '0;
    in_sprite_bits = '0;
    in_colour      = '0;
    in_object_kind = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: empty store, edge columns, off screen rows, every colour class
    read_row(0);
    read_row(63);
    request(ACT_DRAW, 8'sd0, 3'd0, 8'sd0, 8'hFF, COLOUR_WHITE, KIND_FRIEND);
    request(ACT_DRAW, 8'sd0, 3'd1, 8'sd55, 8'hFF, 4'd1, KIND_ENEMY);
    request(ACT_DRAW, 8'sd60, 3'd3, -8'sd8, 8'h81, 4'd2, KIND_LIFE);
    request(ACT_DRAW, 8'sd60, 3'd4, 8'sd10, 8'hFF, 4'd4, KIND_FRIEND);
    request(ACT_DRAW, -8'sd128, 3'd7, 8'sd10, 8'hFF, 4'd5, KIND_FRIEND);
    request(ACT_DRAW, -8'sd3, 3'd7, 8'sd127, 8'hFF, 4'd5, KIND_FRIEND);
    request(ACT_DRAW, 8'sd4, 3'd0, -8'sd128, 8'hFF, 4'd3, KIND_ENEMY);
    request(ACT_DRAW, 8'sd0, 3'd0, 8'sd4, 8'hAA, COLOUR_OFF, KIND_LIFE);
    request(ACT_DRAW, 8'sd0, 3'd0, 8'sd2, 8'h0F, COLOUR_FILL, KIND_ENEMY);
    request(ACT_DRAW, 8'sd0, 3'd0, 8'sd30, 8'hF0, 4'd15, KIND_LIFE);
    request(ACT_DRAW, 8'sd0, 3'd1, 8'sd56, 8'h81, 4'd6, 2'd0);
    request(ACT_DRAW, 8'sd2, 3'd0, 8'sd20, 8'h3C, 4'd3, KIND_FRIEND);
    request(ACT_DRAW, 8'sd2, 3'd0, 8'sd22, 8'h55, 4'd4, KIND_ENEMY);
    read_row(0);
    read_row(1);
    read_row(2);
    read_row(63);
    read_row(-1);
    read_row(64);
    read_row(127);
    read_row(-128);
    request(ACT_CLEAR, 8'sd0, 3'd7, -8'sd1, 8'hFF, 4'hF, 2'd3);
    request(ACT_CLEAR, 8'sd127, 3'd0, 8'sd0, 8'h00, 4'd0, 2'd0);
    request(ACT_NONE, 8'sd1, 3'd0, 8'sd0, 8'hFF, 4'd7, KIND_FRIEND);
    read_row(0);
    read_row(1);

    // random: mostly whole sprites followed by reads, plus clears and noise
    while (sent < TOTAL_REQS) begin
      group = $urandom_range(0, 99);
      if (group < 55) begin
        t      = $urandom_range(0, 70) - 7;
        c      = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255) - 128
                                             : $urandom_range(0, 79) - 12;
        clr    = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
                                             : 4'($urandom_range(1, 7));
        kd     = 2'($urandom_range(0, 3));
        broken = ($urandom_range(0, 9) == 0);
        for (int n = 0; n < 8; n++)
          request(ACT_DRAW, t[7:0], broken ? 3'($urandom) : n[2:0], c[7:0],
                  8'($urandom), clr, kd);
        repeat ($urandom_range(1, 3)) begin
          r = t + $urandom_range(0, 7);
          read_row(r);
        end
      end else if (group < 80) begin
        r = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) - 128
                                        : $urandom_range(0, 63);
        read_row(r);
      end else if (group < 90) begin
        r = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) - 128
                                        : $urandom_range(0, 63);
        request(ACT_CLEAR, r[7:0], 3'($urandom), 8'($urandom), 8'($urandom),
                4'($urandom), 2'($urandom));
        if ($urandom_range(0, 1) == 1) read_row(r);
      end else begin
        request(action_t'(2'($urandom)), 8'($urandom), 3'($urandom), 8'($urandom),
                8'($urandom), 4'($urandom), 2'($urandom));
      end
    end
    start <= 1'b0;

    // drain outstanding reads, then let the pipeline settle
    while (sb.pending_reads.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.errors == 0 && sb.pending_reads.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
